// ===== rtl/bxema_pkg.sv =====
// ----------------------------------------------------------------------------
// bxema_pkg
// Shared widths, constants and types of the boxcar plus exponential filter.
// ----------------------------------------------------------------------------
package bxema_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ALPHA_W  = 17;
    localparam int STATE_W  = 32;

    // default boxcar length
    localparam int WINDOW_LEN_DEF = 5;

    // Q1.16 weight, 65536 is one
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h08000;

    // one sample of each sensor, moved as a unit along the cell row
    typedef struct packed {
        logic [SAMPLE_W-1:0] front;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } sample_set_t;

    // per-stage advance strobes handed to each channel
    typedef struct packed {
        logic load;
        logic avg_en;
        logic ema_en;
    } chan_ctrl_t;

endpackage

// ===== rtl/bxema_if.sv =====
// ----------------------------------------------------------------------------
// bxema_if
// Valid/ready channel interfaces: sample input, filtered output, alpha write.
// ----------------------------------------------------------------------------
interface bxema_in_if;
    logic                          valid;
    logic                          ready;
    logic [bxema_pkg::SAMPLE_W-1:0] front_sample;
    logic [bxema_pkg::SAMPLE_W-1:0] left_sample;
    logic [bxema_pkg::SAMPLE_W-1:0] right_sample;

    modport source (
        output valid, front_sample, left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, front_sample, left_sample, right_sample,
        output ready
    );
endinterface

interface bxema_out_if;
    logic                          valid;
    logic                          ready;
    logic [bxema_pkg::SAMPLE_W-1:0] front_filtered;
    logic [bxema_pkg::SAMPLE_W-1:0] left_filtered;
    logic [bxema_pkg::SAMPLE_W-1:0] right_filtered;

    modport source (
        output valid, front_filtered, left_filtered, right_filtered,
        input  ready
    );
    modport sink (
        input  valid, front_filtered, left_filtered, right_filtered,
        output ready
    );
endinterface

interface bxema_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bxema_pkg::ALPHA_W-1:0] smoothing_alpha;

    modport source (
        output valid, smoothing_alpha,
        input  ready
    );
    modport sink (
        input  valid, smoothing_alpha,
        output ready
    );
endinterface

// ===== rtl/bxema_cell.sv =====
// ----------------------------------------------------------------------------
// bxema_cell
// One window slot: holds a sample of each sensor and passes it on each shift.
// ----------------------------------------------------------------------------
module bxema_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  bxema_pkg::sample_set_t prev,
    output bxema_pkg::sample_set_t held
);
    import bxema_pkg::*;

    sample_set_t held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (shift)
        begin
            held_reg <= prev;
        end
    end

    assign held = held_reg;

endmodule

// ===== rtl/bxema_chan.sv =====
// ----------------------------------------------------------------------------
// bxema_chan
// One sensor channel: running window sum, divide by length, smoothing step.
// ----------------------------------------------------------------------------
module bxema_chan #(
    parameter int WINDOW_LEN = bxema_pkg::WINDOW_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bxema_pkg::chan_ctrl_t         ctrl,
    input  logic [bxema_pkg::SAMPLE_W-1:0] fresh_sample,
    input  logic [bxema_pkg::SAMPLE_W-1:0] oldest_sample,
    input  logic [bxema_pkg::ALPHA_W-1:0]  alpha,
    input  logic [bxema_pkg::ALPHA_W-1:0]  alpha_rest,
    output logic [bxema_pkg::SAMPLE_W-1:0] filtered
);
    import bxema_pkg::*;

    localparam int LEN_BITS  = $clog2(WINDOW_LEN);
    localparam int SUM_W     = SAMPLE_W + LEN_BITS;
    // exact reciprocal: ceil(2^(SUM_W+LEN_BITS) / WINDOW_LEN)
    localparam int DIV_SHIFT = SUM_W + LEN_BITS;
    localparam int MUL_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam longint DIV_NUM = longint'(1) << DIV_SHIFT;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'((DIV_NUM + WINDOW_LEN - 1) / WINDOW_LEN);
    localparam int FRESH_W   = ALPHA_W + SAMPLE_W;
    localparam int KEEP_W    = ALPHA_W + STATE_W;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] avg_next;
    logic [STATE_W-1:0]  state_reg;
    logic [STATE_W-1:0]  state_next;
    logic [PROD_W-1:0]   quot_prod;
    logic [FRESH_W-1:0]  fresh_term;
    logic [KEEP_W-1:0]   keep_full;
    logic [FRESH_W-1:0]  ema_sum;

    // window sum tracks entering and leaving samples
    assign sum_next = sum_reg + SUM_W'(fresh_sample) - SUM_W'(oldest_sample);

    assign quot_prod = PROD_W'(sum_reg) * PROD_W'(DIV_MUL);
    assign avg_next  = quot_prod[DIV_SHIFT +: SAMPLE_W];

    assign fresh_term = FRESH_W'(alpha) * FRESH_W'(avg_reg);
    assign keep_full  = KEEP_W'(alpha_rest) * KEEP_W'(state_reg);
    assign ema_sum    = fresh_term + keep_full[KEEP_W-1:16];
    assign state_next = ema_sum[STATE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            state_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                sum_reg <= sum_next;
            end
            if (ctrl.ema_en)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.avg_en)
        begin
            avg_reg <= avg_next;
        end
    end

    assign filtered = state_reg[STATE_W-1:16];

endmodule

// ===== rtl/three_channel_boxcar_ema_filter.sv =====
// ----------------------------------------------------------------------------
// three_channel_boxcar_ema_filter
// Three-sensor moving average followed by exponential smoothing.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless a held result backs up the pipeline:
// the sample set shifts into a row of WINDOW_LEN cells while each channel's
// window sum register is updated, the average stage divides the sum by the
// window length through a constant reciprocal multiply, and the result stage
// runs the smoothing step, whose 17 by 32 bit multiply feeding back into the
// Q16.16 state register sets the clock. The result register frees as it is
// read, so a waiting result does not hold up input while earlier stages are
// empty. Samples input ready follows results ready within the same cycle.
// Alpha writes above one are stored as one.
module three_channel_boxcar_ema_filter #(
    parameter int WINDOW_LEN = bxema_pkg::WINDOW_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bxema_in_if.sink     samples,
    bxema_out_if.source  results,
    bxema_cfg_if.sink    cfg
);
    import bxema_pkg::*;

    logic [ALPHA_W-1:0] alpha_reg;
    logic [ALPHA_W-1:0] alpha_next;
    logic [ALPHA_W-1:0] alpha_rest;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;
    logic adv12, adv23, load;

    chan_ctrl_t  ctrl;
    sample_set_t chain [0:WINDOW_LEN];

    // alpha register
    assign cfg.ready  = 1'b1;
    assign alpha_next = (cfg.smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_alpha;
    assign alpha_rest = ALPHA_ONE - alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg.valid)
        begin
            alpha_reg <= alpha_next;
        end
    end

    // stage occupancy: window sum, average, smoothed result
    assign rdy3  = !v3_reg || results.ready;
    assign adv23 = v2_reg && rdy3;
    assign rdy2  = !v2_reg || rdy3;
    assign adv12 = v1_reg && rdy2;
    assign rdy1  = !v1_reg || rdy2;
    assign load  = samples.valid && rdy1;

    assign samples.ready = rdy1;

    assign v1_next = load || (v1_reg && !adv12);
    assign v2_next = adv12 || (v2_reg && !adv23);
    assign v3_next = adv23 || (v3_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign ctrl.load   = load;
    assign ctrl.avg_en = adv12;
    assign ctrl.ema_en = adv23;

    // cell row: the last cell's sample leaves the window on each transfer
    assign chain[0].front = samples.front_sample;
    assign chain[0].left  = samples.left_sample;
    assign chain[0].right = samples.right_sample;

    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        bxema_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (load),
            .prev  (chain[i]),
            .held  (chain[i+1])
        );
    end

    bxema_chan #(.WINDOW_LEN(WINDOW_LEN)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .fresh_sample  (chain[0].front),
        .oldest_sample (chain[WINDOW_LEN].front),
        .alpha         (alpha_reg),
        .alpha_rest    (alpha_rest),
        .filtered      (results.front_filtered)
    );

    bxema_chan #(.WINDOW_LEN(WINDOW_LEN)) u_left (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .fresh_sample  (chain[0].left),
        .oldest_sample (chain[WINDOW_LEN].left),
        .alpha         (alpha_reg),
        .alpha_rest    (alpha_rest),
        .filtered      (results.left_filtered)
    );

    bxema_chan #(.WINDOW_LEN(WINDOW_LEN)) u_right (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .fresh_sample  (chain[0].right),
        .oldest_sample (chain[WINDOW_LEN].right),
        .alpha         (alpha_reg),
        .alpha_rest    (alpha_rest),
        .filtered      (results.right_filtered)
    );

    assign results.valid = v3_reg;

endmodule

// ===== sim/bxema_filter_checker.sv =====
// ----------------------------------------------------------------------------
// bxema_filter_checker
// Watches the sample, result and alpha channels of the boxcar plus
// exponential filter, predicts each filtered set from the accepted samples
// and the current alpha, and compares results field by field, in order.
// ----------------------------------------------------------------------------
module bxema_filter_checker #(
    parameter int WINDOW_LEN = bxema_pkg::WINDOW_LEN_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    bxema_in_if   samples,
    bxema_out_if  results,
    bxema_cfg_if  cfg,
    output int    mismatch_count,
    output int    outstanding
);
    import bxema_pkg::*;

    localparam int REPORT_LIMIT = 10;

    sample_set_t          sample_ring [WINDOW_LEN];
    int                   ring_slot;
    logic [STATE_W-1:0]   front_level;
    logic [STATE_W-1:0]   left_level;
    logic [STATE_W-1:0]   right_level;
    logic [ALPHA_W-1:0]   alpha_reg;
    sample_set_t          expected_filtered [$];

    // one Q16.16 low-pass step, the decay term truncated
    function automatic logic [STATE_W-1:0] smooth_step(
        input logic [STATE_W-1:0]  level,
        input logic [SAMPLE_W-1:0] mean,
        input logic [ALPHA_W-1:0]  weight
    );
        logic [ALPHA_W-1:0] keep_weight;
        logic [63:0]        fresh;
        logic [63:0]        kept;
        keep_weight = ALPHA_ONE - weight;
        fresh = 64'(weight) * 64'(mean);
        kept  = (64'(keep_weight) * 64'(level)) >> 16;
        return STATE_W'(fresh + kept);
    endfunction

    task automatic check_field(
        input string               field,
        input logic [SAMPLE_W-1:0] want,
        input logic [SAMPLE_W-1:0] got
    );
        if (got !== want)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        sample_set_t        want;
        int unsigned        front_acc;
        int unsigned        left_acc;
        int unsigned        right_acc;
        logic [ALPHA_W-1:0] weight;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                sample_ring[i] = '0;
            ring_slot      = 0;
            front_level    = '0;
            left_level     = '0;
            right_level    = '0;
            alpha_reg      = ALPHA_RESET;
            expected_filtered.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                alpha_reg = cfg.smoothing_alpha;

            // a result never leaves in the same cycle as the transfer that caused it
            if (results.valid && results.ready)
            begin
                if (expected_filtered.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: unexpected result %h %h %h", $realtime,
                                 results.front_filtered, results.left_filtered,
                                 results.right_filtered);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    check_field("front_filtered", want.front, results.front_filtered);
                    check_field("left_filtered", want.left, results.left_filtered);
                    check_field("right_filtered", want.right, results.right_filtered);
                end
            end

            if (samples.valid && samples.ready)
            begin
                sample_ring[ring_slot] = '{front: samples.front_sample,
                                           left:  samples.left_sample,
                                           right: samples.right_sample};
                ring_slot = (ring_slot >= WINDOW_LEN - 1) ? 0 : ring_slot + 1;
                front_acc = 0;
                left_acc  = 0;
                right_acc = 0;
                for (int i = 0; i < WINDOW_LEN; i++)
                begin
                    front_acc += sample_ring[i].front;
                    left_acc  += sample_ring[i].left;
                    right_acc += sample_ring[i].right;
                end
                // weights above one act as one
                weight = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
                front_level = smooth_step(front_level, 16'(front_acc / WINDOW_LEN), weight);
                left_level  = smooth_step(left_level, 16'(left_acc / WINDOW_LEN), weight);
                right_level = smooth_step(right_level, 16'(right_acc / WINDOW_LEN), weight);
                want = '{front: front_level[31:16],
                         left:  left_level[31:16],
                         right: right_level[31:16]};
                expected_filtered.push_back(want);
            end

            outstanding = expected_filtered.size();
        end
    end

endmodule

// ===== sim/three_channel_boxcar_ema_filter_test.sv =====
// ----------------------------------------------------------------------------
// three_channel_boxcar_ema_filter_test
// Drives sample sets and alpha writes into the filter under random idling on
// both sides, with a long result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module three_channel_boxcar_ema_filter_test;

    import bxema_pkg::*;

    localparam int WINDOW_LEN       = WINDOW_LEN_DEF;
    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 6;
    localparam int MAX_IDLE         = 16;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASES           = 8;
    localparam int RANDOM_ITEMS     = 1500;
    localparam int TIMEOUT          = 2_000_000;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   outstanding;
    bit   source_eager;
    bit   sink_eager;
    bit   hold_results;

    bxema_in_if  samples ();
    bxema_out_if results ();
    bxema_cfg_if cfg ();

    three_channel_boxcar_ema_filter #(
        .WINDOW_LEN (WINDOW_LEN)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    bxema_filter_checker #(
        .WINDOW_LEN (WINDOW_LEN)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples),
        .results        (results),
        .cfg            (cfg),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
        clk = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int stall;
        results.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                results.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            stall = sink_eager ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                results.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!(results.valid && results.ready));
            @(negedge clk);
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(0, 15));
            3:       return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_set(
        input logic [SAMPLE_W-1:0] front,
        input logic [SAMPLE_W-1:0] left,
        input logic [SAMPLE_W-1:0] right
    );
        int gap;
        gap = source_eager ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples.front_sample <= front;
        samples.left_sample  <= left;
        samples.right_sample <= right;
        samples.valid        <= 1'b1;
        do @(posedge clk); while (!(samples.valid && samples.ready));
        @(negedge clk);
    endtask

    task automatic drain_results();
        samples.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_alpha(input logic [ALPHA_W-1:0] value);
        drain_results();
        cfg.smoothing_alpha <= value;
        cfg.valid           <= 1'b1;
        do @(posedge clk); while (!(cfg.valid && cfg.ready));
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [ALPHA_W-1:0] phase_alpha [PHASES];
        samples.valid        = 1'b0;
        samples.front_sample = '0;
        samples.left_sample  = '0;
        samples.right_sample = '0;
        cfg.valid            = 1'b0;
        cfg.smoothing_alpha  = '0;
        source_eager         = 1'b0;
        sink_eager           = 1'b0;
        hold_results         = 1'b0;
        rst_n                = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset weight of one half; seven sets wrap the ring
        send_set('0, '0, '0);
        send_set('1, '1, '1);
        send_set('1, '0, 16'hAAAA);
        send_set(16'h5555, 16'hAAAA, '1);
        send_set(16'h8000, 16'h0001, 16'h7FFF);
        send_set('1, '1, '1);
        send_set('1, '1, '1);

        // weight of one: output follows the window mean
        write_alpha(ALPHA_ONE);
        send_set('0, '1, 16'h1234);
        send_set('1, '0, 16'hFEDC);
        send_set(16'h00FF, 16'hFF00, '0);

        // zero weight freezes the smoothed state
        write_alpha('0);
        send_set('0, '0, '0);
        send_set('1, '1, '1);
        send_set(16'h0F0F, 16'hF0F0, 16'h3C3C);

        // weights above one clamp to one
        write_alpha('1);
        send_set('1, '1, '1);
        send_set('0, '0, '0);
        send_set(16'hA5A5, 16'h5A5A, 16'hFFFE);

        write_alpha(17'd1);
        send_set('1, '1, '1);
        send_set('0, 16'h0001, '1);

        phase_alpha = '{ALPHA_RESET, ALPHA_ONE, 17'h00000, 17'h1FFFF,
                        17'h00001, 17'h0FFFF, 17'h10001, 17'h04000};
        phase_alpha[PHASES - 1] = ALPHA_W'($urandom_range(1, 17'h1FFFF));

        for (int p = 0; p < PHASES; p++)
        begin
            write_alpha(phase_alpha[p]);
            source_eager = ($urandom_range(0, 3) == 0);
            sink_eager   = ($urandom_range(0, 3) == 0);
            // back-to-back input while results are held fills the pipe
            if (p == 1)
                source_eager = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (p == 1 && n == 20)
                    hold_results = 1'b1;
                send_set(pick_sample(), pick_sample(), pick_sample());
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bxema_pkg.sv
rtl/bxema_if.sv
rtl/bxema_cell.sv
rtl/bxema_chan.sv
rtl/three_channel_boxcar_ema_filter.sv
sim/bxema_filter_checker.sv
sim/three_channel_boxcar_ema_filter_test.sv
